// ===== design/bswe_pkg.sv =====
// Shared types, constants and helper functions for the byte stack with extract.
package bswe_pkg;

	localparam int DEPTH = 64;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		ACT_PUSH    = 2'd0,
		ACT_POP     = 2'd1,
		ACT_EXTRACT = 2'd2
	} act_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EMPTY     = 2'd1,
		ST_FULL      = 2'd2,
		ST_NOT_FOUND = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		OP_HOLD    = 2'd0,
		OP_PUSH    = 2'd1,
		OP_POP     = 2'd2,
		OP_EXTRACT = 2'd3
	} cell_op_t;

	typedef struct packed {
		cell_op_t op;
		logic     sel;
	} cell_ctl_t;

	// Prefix OR from the top cell downward, built as a log-depth tree.
	function automatic logic [DEPTH-1:0] prefix_or(input logic [DEPTH-1:0] v);
		logic [DEPTH-1:0] p;
		logic [DEPTH-1:0] q;
		p = v;
		for (int l = 0; l < IDX_W; l++) begin
			q = p;
			for (int i = 0; i < DEPTH; i++) begin
				if (i >= (1 << l)) begin
					p[i] = q[i] | q[i - (1 << l)];
				end
			end
		end
		return p;
	endfunction

endpackage

// ===== design/bswe_cell.sv =====
// One storage cell of the stack chain: holds a byte and shifts with its neighbors.
module bswe_cell (
	input  logic               clk,
	input  bswe_pkg::cell_ctl_t ctl,
	input  logic [7:0]         upper_data,
	input  logic [7:0]         lower_data,
	input  logic [7:0]         key,
	output logic [7:0]         data,
	output logic               match
);
	import bswe_pkg::*;

	logic [7:0] data_q;

	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_HOLD: begin
			end
			OP_PUSH: begin
				data_q <= upper_data;
			end
			OP_POP: begin
				data_q <= lower_data;
			end
			OP_EXTRACT: begin
				// Cells at or below the removed entry close the gap.
				if (ctl.sel) begin
					data_q <= lower_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign data  = data_q;
	assign match = (data_q == key);

endmodule

// ===== design/byte_stack_with_extract.sv =====
// Top level of the byte stack with extract: control, count and the cell chain.
//
// A transaction is accepted at a rising edge where start is high and busy is
// low; action and value are sampled there. Push and pop need no second step:
// done pulses in the cycle after acceptance and busy stays low, so a
// new transaction may follow at once. Extract runs as a compare step, which
// checks every cell against value and registers the hit vector, and then a
// resolve step, which finds the topmost hit and shifts the cells below it;
// busy is high for the resolve step and done pulses the cycle after it.
// The result (result_byte, status, entry_count, is_vacant) is on the ports
// for exactly the one cycle that done is high; the receiver cannot stall it.
// The top of the stack sits in cell 0; push shifts the chain away from it,
// pop shifts it toward it. Reset clears the count and all control state; the
// cell contents are meaningless until pushed.
module byte_stack_with_extract (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	output logic                       busy,
	input  logic [1:0]                 action,
	input  logic [7:0]                 value,
	output logic                       done,
	output logic [7:0]                 result_byte,
	output logic [1:0]                 status,
	output logic [bswe_pkg::CNT_W-1:0] entry_count,
	output logic                       is_vacant
);
	import bswe_pkg::*;

	logic             accept;
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;
	logic             ext_pending_q;
	logic             ext_pending_d;
	logic [DEPTH-1:0] hits_s1;
	logic [DEPTH-1:0] hits_raw;
	logic [DEPTH-1:0] remove_sel;
	logic [7:0]       value_s1;
	logic [7:0]       cell_data [DEPTH];
	cell_op_t         op_d;
	logic             done_q;
	logic             done_d;
	logic [7:0]       byte_q;
	logic [7:0]       byte_d;
	status_t          status_q;
	status_t          status_d;
	logic [CNT_W-1:0] out_count_q;

	assign accept     = start && !busy;
	assign busy       = ext_pending_q;
	assign remove_sel = prefix_or(hits_s1);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		cell_ctl_t  ctl;
		logic [7:0] upper;
		logic [7:0] lower;
		logic       hit;

		assign ctl.op  = op_d;
		assign ctl.sel = remove_sel[i];

		if (i == 0) begin : g_top
			assign upper = value;
		end else begin : g_mid
			assign upper = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_bottom
			assign lower = 8'd0;
		end else begin : g_above
			assign lower = cell_data[i+1];
		end

		bswe_cell u_cell (
			.clk        (clk),
			.ctl        (ctl),
			.upper_data (upper),
			.lower_data (lower),
			.key        (value),
			.data       (cell_data[i]),
			.match      (hit)
		);

		// Only cells below the count hold live entries.
		assign hits_raw[i] = hit && (CNT_W'(i) < count_q);
	end

	always_comb begin
		op_d          = OP_HOLD;
		count_d       = count_q;
		ext_pending_d = 1'b0;
		done_d        = 1'b0;
		byte_d        = 8'd0;
		status_d      = ST_OK;
		if (ext_pending_q) begin
			done_d = 1'b1;
			if (|hits_s1) begin
				op_d    = OP_EXTRACT;
				count_d = count_q - CNT_W'(1);
				byte_d  = value_s1;
			end else begin
				status_d = ST_NOT_FOUND;
			end
		end else if (accept) begin
			unique case (act_t'(action))
				ACT_PUSH: begin
					done_d = 1'b1;
					if (count_q == CNT_W'(DEPTH)) begin
						status_d = ST_FULL;
					end else begin
						op_d    = OP_PUSH;
						count_d = count_q + CNT_W'(1);
					end
				end
				ACT_POP: begin
					done_d = 1'b1;
					if (count_q == '0) begin
						status_d = ST_EMPTY;
					end else begin
						op_d    = OP_POP;
						count_d = count_q - CNT_W'(1);
						byte_d  = cell_data[0];
					end
				end
				ACT_EXTRACT: begin
					ext_pending_d = 1'b1;
				end
				default: begin
					done_d = 1'b1;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= '0;
			ext_pending_q <= 1'b0;
			done_q        <= 1'b0;
		end else begin
			count_q       <= count_d;
			ext_pending_q <= ext_pending_d;
			done_q        <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		hits_s1     <= hits_raw;
		value_s1    <= value;
		byte_q      <= byte_d;
		status_q    <= status_d;
		out_count_q <= count_d;
	end

	assign done        = done_q;
	assign result_byte = byte_q;
	assign status      = status_q;
	assign entry_count = out_count_q;
	assign is_vacant   = (out_count_q == '0);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("stack count exceeds depth");

	a_ext_two_cycles: assert property (@(posedge clk) disable iff (!arst_n)
		ext_pending_q |=> !ext_pending_q)
		else $error("extract resolve lasted more than one cycle");

	a_ext_hit_count: assert property (@(posedge clk) disable iff (!arst_n)
		(ext_pending_q && (|hits_s1)) |=> (count_q == $past(count_q) - CNT_W'(1)))
		else $error("successful extract did not remove one entry");

	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($past(ext_pending_q) ||
			($past(accept) && ($past(action) != ACT_EXTRACT))))
		else $error("result strobe without a finished transaction");

	a_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && (status_q == ST_FULL)) |-> (out_count_q == CNT_W'(DEPTH)))
		else $error("full status reported on a stack that is not full");

endmodule
